// ===== hw/rtl/ipral_pkg.sv =====
// Shared types and constants for the IPv4 range allowlist match unit.
// Holds the mode codes, the rule layout and the item record carried along the cell chain.
// No dependencies.
package ipral_pkg;

    localparam int MAX_RULES_DEF = 16;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 8;

    // Octet k of a rule sits at index k; octet 0 is the address's top byte.
    typedef struct packed {
        logic [3:0][7:0] lo;
        logic [3:0][7:0] hi;
    } ipral_rule_t;

    localparam ipral_rule_t LOOPBACK_RULE = '{
        lo: {8'd1, 8'd0, 8'd0, 8'd127},
        hi: {8'd1, 8'd0, 8'd0, 8'd127}
    };

    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic [31:0] addr;
        ipral_rule_t rule;
        logic        hit;
        logic        dropped;
    } ipral_tok_t;

endpackage

// ===== hw/rtl/ipral_head.sv =====
// Front of the cell chain: keeps the rule count, orders the bounds of a new rule
// and decides whether an add is dropped. Depends on ipral_pkg.
module ipral_head #(
    parameter int MAX_RULES = ipral_pkg::MAX_RULES_DEF,
    parameter int CNT_W     = $clog2(MAX_RULES + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic [ipral_pkg::IN_TDATA_W-1:0] in_data,
    output ipral_pkg::ipral_tok_t            tok_out,
    output logic [CNT_W-1:0]                 cnt_out
);
    import ipral_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RULES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       mode;
    logic             full;
    logic [7:0]       a_oct [4];
    logic [7:0]       b_oct [4];

    assign mode = in_data[1:0];
    assign full = (count_reg == CNT_FULL);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            a_oct[k] = in_data[34 + 16 * k +: 8];
            b_oct[k] = in_data[42 + 16 * k +: 8];
        end
        tok_out.valid   = in_valid;
        tok_out.mode    = mode;
        tok_out.addr    = in_data[33:2];
        tok_out.hit     = 1'b0;
        tok_out.dropped = (mode == MODE_ADD) && full;
        // swap reversed bounds
        for (int k = 0; k < 4; k++) begin
            if (a_oct[k] < b_oct[k]) begin
                tok_out.rule.lo[k] = a_oct[k];
                tok_out.rule.hi[k] = b_oct[k];
            end else begin
                tok_out.rule.lo[k] = b_oct[k];
                tok_out.rule.hi[k] = a_oct[k];
            end
        end
    end

    assign cnt_out = count_reg;

    always_comb begin
        count_next = count_reg;
        if (in_valid && adv) begin
            priority if (mode == MODE_CLEAR) begin
                count_next = CNT_ONE;
            end else if (mode == MODE_ADD && !full) begin
                count_next = count_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_ONE;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ipral_cell.sv =====
// One cell of the rule chain: holds one rule, checks passing items against it
// and stores an added rule aimed at its slot. Depends on ipral_pkg.
module ipral_cell #(
    parameter int MAX_RULES = ipral_pkg::MAX_RULES_DEF,
    parameter int CNT_W     = $clog2(MAX_RULES + 1),
    parameter int INDEX     = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  ipral_pkg::ipral_tok_t tok_in,
    input  logic [CNT_W-1:0]      cnt_in,
    output ipral_pkg::ipral_tok_t tok_out,
    output logic [CNT_W-1:0]      cnt_out
);
    import ipral_pkg::*;

    localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

    ipral_rule_t rule;
    ipral_tok_t  tok_reg;
    ipral_tok_t  tok_next;
    logic [CNT_W-1:0] cnt_reg;
    logic        in_range;
    logic        hit_here;

    generate
        if (INDEX == 0) begin : g_fixed
            // slot 0 is always the loopback rule
            assign rule = LOOPBACK_RULE;
        end else begin : g_store
            ipral_rule_t rule_reg;
            always_ff @(posedge aclk) begin
                if (adv && tok_in.valid && tok_in.mode == MODE_ADD && !tok_in.dropped
                    && cnt_in == SLOT) begin
                    rule_reg <= tok_in.rule;
                end
            end
            assign rule = rule_reg;
        end
    endgenerate

    always_comb begin
        in_range = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (tok_in.addr[31 - 8 * k -: 8] < rule.lo[k] ||
                tok_in.addr[31 - 8 * k -: 8] > rule.hi[k]) begin
                in_range = 1'b0;
            end
        end
        hit_here = (tok_in.mode == MODE_CHECK) && (cnt_in > SLOT) && in_range;
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | hit_here;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            tok_reg <= tok_next;
            cnt_reg <= cnt_in;
        end
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

// ===== hw/rtl/ipv4_range_allowlist_match_unit.sv =====
// Top level of the IPv4 range allowlist match unit: head stage plus a chain
// of MAX_RULES rule cells. Depends on ipral_pkg, ipral_head and ipral_cell.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata; each carries a mode
//   (clear the table, add a rule, check an address), an address and four
//   low/high octet bound pairs. Every item yields exactly one result item on
//   m_tvalid/m_tready/m_tdata: allowed (set for a check that hits some rule)
//   and rule_dropped (set for an add that found the table full).
//   Each item walks the chain one cell per cycle while the chain advances;
//   cell i holds rule i, tests the item's address against it and ORs its
//   verdict into the item. An add is written into the cell whose slot equals
//   the rule count taken at entry. Each cell registers the item on its way;
//   a new item can enter every cycle while the chain is not held, so
//   throughput is one item per cycle; the last cell's register holds the result.
//   After reset the table holds only the loopback rule 127.0.0.1 in slot 0
//   and the rule count is 1; the chain is empty.
//   When the receiver stalls with a result pending, the whole chain and the
//   head hold, and s_tready drops until the result is taken.
module ipv4_range_allowlist_match_unit #(
    parameter int MAX_RULES = ipral_pkg::MAX_RULES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, low bit up: mode[1:0], address[33:2], low_octet0, high_octet0,
    // low_octet1, high_octet1, low_octet2, high_octet2, low_octet3,
    // high_octet3 (8 bits each from bit 34), zeros in [103:98]
    input  logic [ipral_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, low bit up: allowed[0], rule_dropped[1], zeros in [7:2]
    output logic [ipral_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ipral_pkg::*;

    localparam int CNT_W = $clog2(MAX_RULES + 1);

    ipral_tok_t       tok_w [MAX_RULES + 1];
    logic [CNT_W-1:0] cnt_w [MAX_RULES + 1];
    logic             adv;
    ipral_tok_t       tok_last;

    // advance the chain unless a finished result is still waiting
    assign tok_last = tok_w[MAX_RULES];
    assign adv      = !tok_last.valid || m_tready;
    assign s_tready = adv;

    ipral_head #(
        .MAX_RULES(MAX_RULES),
        .CNT_W    (CNT_W)
    ) u_head (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_valid(s_tvalid),
        .in_data (s_tdata),
        .tok_out (tok_w[0]),
        .cnt_out (cnt_w[0])
    );

    generate
        for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
            ipral_cell #(
                .MAX_RULES(MAX_RULES),
                .CNT_W    (CNT_W),
                .INDEX    (i)
            ) u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .adv    (adv),
                .tok_in (tok_w[i]),
                .cnt_in (cnt_w[i]),
                .tok_out(tok_w[i + 1]),
                .cnt_out(cnt_w[i + 1])
            );
        end
    endgenerate

    // the last cell's register is the output stage
    assign m_tvalid = tok_last.valid;
    assign m_tdata  = {6'd0, tok_last.dropped, tok_last.hit};

endmodule

// ===== bench/ipv4_range_allowlist_match_unit_tb.sv =====
// Self-checking bench for ipv4_range_allowlist_match_unit: directed table, then random traffic.
// Keeps its own copy of the rule table to predict every verdict; uses types from ipral_pkg.
// Needs only the RTL (ipral_pkg and the unit with its head and cells).
module ipv4_range_allowlist_match_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ipral_pkg::*;

    // Mode 3 is unused by the block: it must change nothing and answer zero.
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;
    localparam int unsigned RAND_ITEMS    = 1250;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned TAIL_CYCLES   = 4 * MAX_RULES_DEF;
    localparam int unsigned REPORT_LIMIT  = 10;

    // One input item. Bounds are kept in address order: octet k in bits 31-8k.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] addr;
        logic [31:0] bound_a;
        logic [31:0] bound_b;
    } acl_item_t;

    typedef struct packed {
        logic dropped;
        logic allowed;
    } verdict_t;

    // Row of the directed table; known rows carry a verdict typed in by hand.
    typedef struct {
        acl_item_t   item;
        int unsigned reps;
        bit          known;
        verdict_t    verdict;
    } stim_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Predictor state: rule bounds in address order and the number of live rules.
    logic [31:0] rule_lo [MAX_RULES_DEF];
    logic [31:0] rule_hi [MAX_RULES_DEF];
    int unsigned rule_total;

    verdict_t    verdict_q [$];
    stim_row_t   stim_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned result_seq     = 0;

    // Idle percentages of sender and receiver, switched per phase by the main process.
    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 68;
    bit          hold_pending  = 1'b0;

    ipv4_range_allowlist_match_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void load_loopback();
        rule_lo[0] = LOOPBACK_ADDR;
        rule_hi[0] = LOOPBACK_ADDR;
        rule_total = 1;
    endfunction

    // Advance the predicted table by one accepted item and return its verdict.
    function automatic verdict_t apply_item(input acl_item_t it);
        verdict_t    v;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  oct;
        logic [31:0] lo_w;
        logic [31:0] hi_w;
        logic        hit;
        v = '0;
        case (it.mode)
            MODE_CLEAR: begin
                load_loopback();
            end
            MODE_ADD: begin
                if (rule_total >= MAX_RULES_DEF) begin
                    v.dropped = 1'b1;
                end else begin
                    // Swap reversed bounds octet by octet so that low <= high is stored.
                    for (int k = 0; k < 4; k++) begin
                        x = it.bound_a[31-8*k -: 8];
                        y = it.bound_b[31-8*k -: 8];
                        lo_w[31-8*k -: 8] = (x < y) ? x : y;
                        hi_w[31-8*k -: 8] = (x < y) ? y : x;
                    end
                    rule_lo[rule_total] = lo_w;
                    rule_hi[rule_total] = hi_w;
                    rule_total++;
                end
            end
            MODE_CHECK: begin
                for (int i = 0; i < rule_total; i++) begin
                    hit = 1'b1;
                    for (int k = 0; k < 4; k++) begin
                        oct = it.addr[31-8*k -: 8];
                        if (oct < rule_lo[i][31-8*k -: 8] || oct > rule_hi[i][31-8*k -: 8])
                            hit = 1'b0;
                    end
                    if (hit)
                        v.allowed = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    // Random item, shaped mostly as rule additions and checks that aim at live rules.
    function automatic acl_item_t random_item();
        acl_item_t   it;
        int unsigned pick;
        int unsigned idx;
        logic [7:0]  x;
        it.addr    = $urandom;
        it.bound_a = $urandom;
        it.bound_b = $urandom;
        pick = $urandom_range(99);
        if (pick < 3) begin
            it.mode = MODE_CLEAR;
        end else if (pick < 5) begin
            it.mode = MODE_UNUSED;
        end else if (pick < 30) begin
            it.mode = MODE_ADD;
            // Mix wildcards, single values, narrow and arbitrary (often reversed) ranges.
            for (int k = 0; k < 4; k++) begin
                x = 8'($urandom_range(255));
                case ($urandom_range(3))
                    0: begin
                        it.bound_a[31-8*k -: 8] = $urandom_range(1) ? 8'd0 : 8'd255;
                        it.bound_b[31-8*k -: 8] = ~it.bound_a[31-8*k -: 8];
                    end
                    1: begin
                        it.bound_a[31-8*k -: 8] = x;
                        it.bound_b[31-8*k -: 8] = x;
                    end
                    2: begin
                        it.bound_a[31-8*k -: 8] = x;
                        it.bound_b[31-8*k -: 8] = x + 8'($urandom_range(7));
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            it.mode = MODE_CHECK;
            pick = $urandom_range(9);
            if (pick < 6) begin
                // Land in, on the edge of, or just outside a live rule.
                idx = $urandom_range(rule_total - 1);
                for (int k = 0; k < 4; k++) begin
                    x = 8'($urandom_range(rule_hi[idx][31-8*k -: 8], rule_lo[idx][31-8*k -: 8]));
                    if (pick == 5 && $urandom_range(3) == 0)
                        x = $urandom_range(1) ? rule_lo[idx][31-8*k -: 8] - 8'd1
                                              : rule_hi[idx][31-8*k -: 8] + 8'd1;
                    it.addr[31-8*k -: 8] = x;
                end
            end else if (pick == 6) begin
                it.addr = LOOPBACK_ADDR;
            end else if (pick == 7) begin
                it.addr = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
        end
        return it;
    endfunction

    // Offer one item, idling first at the sender's rate; predict it once accepted.
    task automatic offer(input acl_item_t it, input bit known, input verdict_t typed);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0,
                     it.bound_b[7:0],   it.bound_a[7:0],
                     it.bound_b[15:8],  it.bound_a[15:8],
                     it.bound_b[23:16], it.bound_a[23:16],
                     it.bound_b[31:24], it.bound_a[31:24],
                     it.addr, it.mode};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        v = apply_item(it);
        verdict_q.insert(verdict_q.size(), known ? typed : v);
    endtask

    task automatic add_row(input logic [1:0] mode, input logic [31:0] addr,
                           input logic [31:0] bound_a, input logic [31:0] bound_b,
                           input int unsigned reps, input bit known,
                           input logic allowed, input logic dropped);
        stim_row_t row;
        row.item    = '{mode: mode, addr: addr, bound_a: bound_a, bound_b: bound_b};
        row.reps    = reps;
        row.known   = known;
        row.verdict = '{dropped: dropped, allowed: allowed};
        stim_rows.insert(stim_rows.size(), row);
    endtask

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at %0t ns, result %0d: %s", $time, result_seq, msg);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result item with the oldest predicted verdict, field by field.
    always @(posedge aclk) begin : result_check
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.allowed = m_tdata[0];
            got.dropped = m_tdata[1];
            if (verdict_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result allowed=%0b rule_dropped=%0b",
                                        got.allowed, got.dropped));
            end else begin
                want = verdict_q.pop_front();
                if (got.allowed !== want.allowed)
                    flag_mismatch($sformatf("allowed expected %0b got %0b",
                                            want.allowed, got.allowed));
                if (got.dropped !== want.dropped)
                    flag_mismatch($sformatf("rule_dropped expected %0b got %0b",
                                            want.dropped, got.dropped));
            end
            result_seq++;
        end
    end

    // Hard limit on the run; far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        acl_item_t   it;
        int unsigned third;

        rule_lo = '{default: '0};
        rule_hi = '{default: '0};
        load_loopback();

        // Directed table: mode, address, bound a, bound b, repeats, typed?, allowed, dropped.
        add_row(MODE_CHECK,  LOOPBACK_ADDR, '0, '0, 1, 1'b1, 1'b1, 1'b0);
        add_row(MODE_CHECK,  32'h7F00_0002, '0, '0, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h0000_0000, '0, '0, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'hFFFF_FFFF, '0, '0, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 1'b0);
        // Every octet given in reverse: stored swapped.
        add_row(MODE_ADD,    32'h0000_0000, 32'h0A14_1E28, 32'h050F_1923, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h0712_1C25, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h0A14_1E28, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h050F_1923, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h040F_1923, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h0A14_1E29, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        // Full wildcard rule.
        add_row(MODE_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h0000_0000, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'hFFFF_FFFF, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'hFFFF_FFFF, '0, '0, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_CHECK,  LOOPBACK_ADDR, '0, '0, 1, 1'b1, 1'b1, 1'b0);
        // Fill the table, then one more add that must be dropped.
        add_row(MODE_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_ADD,    32'h0000_0000, 32'h0A00_0000, 32'h0A00_00FF, 14, 1'b1, 1'b0, 1'b0);
        add_row(MODE_ADD,    32'h0102_0304, 32'h0102_0304, 32'h0102_0304, 1, 1'b1, 1'b0, 1'b1);
        add_row(MODE_CHECK,  32'h0102_0304, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'hFFFF_FFFF, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_CHECK,  32'h0A00_00FF, '0, '0, 1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_UNUSED, LOOPBACK_ADDR, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_CLEAR,  32'h0000_0000, '0, '0, 1, 1'b1, 1'b0, 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[r]) begin
            for (int n = 0; n < stim_rows[r].reps; n++)
                offer(stim_rows[r].item, stim_rows[r].known, stim_rows[r].verdict);
        end

        // Random part in three phases of idling; the last opens with a long receiver hold.
        third = RAND_ITEMS / 3;
        for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
            if (i == third) begin
                send_idle_pct = 68;
                recv_idle_pct = 25;
            end else if (i == 2 * third) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_pending  = 1'b1;
            end
            it = random_item();
            offer(it, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain, then watch a while longer for stray results.
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
